// File: rtl/core/grd_pkg.sv
// Shared types, constants and helpers for the glyph run-length decoder.
package grd_pkg;

  // Default and widest supported glyph side
  localparam int MAX_DIM_DEF = 256;

  // Register widths of the configuration port
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers
  localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = 9'd8;
  localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 9'd8;
  localparam logic [7:0]           RST_CLAMP  = 8'd255;
  localparam logic                 RST_RLE    = 1'b1;

  // Stream code bytes
  localparam logic [7:0] CODE_NOP      = 8'h80;
  localparam logic [8:0] REPEAT_OFFSET = 9'd257;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CLAMP  = 2'd2,
    REG_RLE    = 2'd3
  } cfg_reg_t;

  // One run segment between the front and back ends
  typedef struct packed {
    logic [7:0] pix;
    logic [7:0] len;
    logic [7:0] row;
    logic [7:0] col;
    logic       done;
  } seg_t;

  // Bound a glyph dimension to 1..lim
  function automatic logic [CFG_DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v,
                                                   input logic [CFG_DIM_W-1:0] lim);
    logic [CFG_DIM_W-1:0] r;
    begin
      if (v == '0) begin
        r = CFG_DIM_W'(1);
      end else if (v > lim) begin
        r = lim;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

// File: rtl/core/grd_front.sv
// Front end: classify stream bytes, track raster position, form run segments.
module grd_front import grd_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_DIM_W-1:0] glyph_width,
  input  logic [CFG_DIM_W-1:0] glyph_height,
  input  logic                 rle_enable,
  input  logic                 size_wr,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           stream_byte,
  output logic                 push,
  output seg_t                 push_seg,
  input  logic                 q_full
);

  localparam int TOT_W = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int POS_W = $clog2(MAX_DIM * MAX_DIM);
  localparam logic [CFG_DIM_W-1:0] DIM_LIM = CFG_DIM_W'(MAX_DIM);

  // RLE decode state
  logic [7:0]       lit_left;
  logic             await_col;
  logic [7:0]       rep_cnt;
  // Position state
  logic [7:0]       row;
  logic [7:0]       col;
  logic [POS_W-1:0] pos;
  logic [TOT_W-1:0] total;
  logic             resync;
  // Row-wrap divider
  logic             div_busy;
  logic [3:0]       div_cnt;
  logic [8:0]       div_num;
  logic [8:0]       div_rem;
  logic [8:0]       div_quo;

  logic [CFG_DIM_W-1:0] w_eff;
  logic [CFG_DIM_W-1:0] h_eff;
  logic                 out_range;
  logic [7:0]           row_e;
  logic [7:0]           col_e;
  logic [POS_W-1:0]     pos_e;
  logic                 take;
  logic                 emit;
  logic [7:0]           emit_len;
  logic [TOT_W-1:0]     left;
  logic                 done;
  logic [7:0]           len_c;
  logic [8:0]           col_sum;
  logic [9:0]           w_dbl;
  logic [8:0]           div_trial;
  logic                 div_ge;

  // Bound dimensions and restart a position left outside the glyph
  always_comb begin
    w_eff     = eff_dim(glyph_width, DIM_LIM);
    h_eff     = eff_dim(glyph_height, DIM_LIM);
    out_range = ({1'b0, row} >= h_eff) || ({1'b0, col} >= w_eff);
    row_e     = out_range ? 8'd0 : row;
    col_e     = out_range ? 8'd0 : col;
    pos_e     = out_range ? '0 : pos;
  end

  assign in_ready = !resync && !div_busy && !q_full;
  assign take     = in_valid && in_ready;

  // Classify the byte
  always_comb begin
    emit     = 1'b0;
    emit_len = 8'd1;
    if (!rle_enable || lit_left != 8'd0) begin
      emit = 1'b1;
    end else if (await_col) begin
      emit     = 1'b1;
      emit_len = rep_cnt;
    end
  end

  // Cut the segment at the glyph end
  always_comb begin
    left    = total - TOT_W'(pos_e);
    done    = (TOT_W'(emit_len) >= left);
    len_c   = done ? left[7:0] : emit_len;
    col_sum = {1'b0, col_e} + {1'b0, len_c};
    w_dbl   = {w_eff, 1'b0};
  end

  // One quotient bit per cycle
  always_comb begin
    div_trial = {div_rem[7:0], div_num[8]};
    div_ge    = (div_trial >= w_eff);
  end

  assign push = take && emit;
  always_comb begin
    push_seg.pix  = stream_byte;
    push_seg.len  = len_c;
    push_seg.row  = row_e;
    push_seg.col  = col_e;
    push_seg.done = done;
  end

  // Advance decode and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_left  <= 8'd0;
      await_col <= 1'b0;
      rep_cnt   <= 8'd0;
      row       <= 8'd0;
      col       <= 8'd0;
      pos       <= '0;
      total     <= '0;
      resync    <= 1'b1;
      div_busy  <= 1'b0;
      div_cnt   <= 4'd0;
      div_num   <= 9'd0;
      div_rem   <= 9'd0;
      div_quo   <= 9'd0;
    end else begin
      // Rebuild the linear position and glyph size after a size write
      if (size_wr) begin
        resync <= 1'b1;
      end else if (resync) begin
        resync <= 1'b0;
      end
      if (resync) begin
        total <= TOT_W'(w_eff) * TOT_W'(h_eff);
        pos   <= POS_W'(POS_W'(row) * POS_W'(w_eff) + POS_W'(col));
      end

      // Finish a multi-row wrap
      if (div_busy) begin
        if (div_cnt == 4'd0) begin
          div_busy <= 1'b0;
          row      <= row + div_quo[7:0];
          col      <= div_rem[7:0];
        end else begin
          div_cnt <= div_cnt - 4'd1;
          div_rem <= div_ge ? (div_trial - w_eff) : div_trial;
          div_quo <= {div_quo[7:0], div_ge};
          div_num <= {div_num[7:0], 1'b0};
        end
      end

      if (take) begin
        // Update run state
        if (rle_enable) begin
          if (lit_left != 8'd0) begin
            lit_left <= lit_left - 8'd1;
          end else if (await_col) begin
            await_col <= 1'b0;
            rep_cnt   <= 8'd0;
          end else if (!stream_byte[7]) begin
            lit_left <= stream_byte + 8'd1;
          end else if (stream_byte != CODE_NOP) begin
            await_col <= 1'b1;
            rep_cnt   <= 8'(REPEAT_OFFSET - {1'b0, stream_byte});
          end
        end

        if (emit) begin
          if (done) begin
            // Glyph complete: drop pending runs and restart
            lit_left  <= 8'd0;
            await_col <= 1'b0;
            rep_cnt   <= 8'd0;
            row       <= 8'd0;
            col       <= 8'd0;
            pos       <= '0;
          end else begin
            pos <= pos_e + POS_W'(len_c);
            if (col_sum < {1'b0, w_eff}) begin
              row <= row_e;
              col <= col_sum[7:0];
            end else if ({1'b0, col_sum} < w_dbl) begin
              row <= row_e + 8'd1;
              col <= 8'(col_sum - w_eff);
            end else begin
              row      <= row_e;
              div_busy <= 1'b1;
              div_cnt  <= 4'd9;
              div_num  <= col_sum;
              div_rem  <= 9'd0;
              div_quo  <= 9'd0;
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/grd_queue.sv
// Two-entry segment queue between the front and back ends.
module grd_queue import grd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  seg_t push_seg,
  output logic full,
  input  logic pop,
  output logic empty,
  output seg_t pop_seg
);

  seg_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_seg = mem[rd_ptr];

  // Store a request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_seg;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/grd_back.sv
// Back end: clamp the pixel, form the column-major index, hold the result.
module grd_back import grd_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_DIM_W-1:0] glyph_height,
  input  logic [7:0]           clamp_max,
  input  logic                 q_empty,
  input  seg_t                 q_seg,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           pixel_value,
  output logic [7:0]           run_length,
  output logic [7:0]           first_row,
  output logic [7:0]           first_col,
  output logic [15:0]          dest_index,
  output logic                 glyph_done
);

  localparam logic [CFG_DIM_W-1:0] DIM_LIM = CFG_DIM_W'(MAX_DIM);

  logic [CFG_DIM_W-1:0] h_eff;
  logic [7:0]           pix_c;
  logic [15:0]          dest;

  // Clamp and index
  always_comb begin
    h_eff = eff_dim(glyph_height, DIM_LIM);
    pix_c = (q_seg.pix > clamp_max) ? clamp_max : q_seg.pix;
    dest  = 16'(16'(q_seg.col) * 16'(h_eff) + 16'(q_seg.row));
  end

  assign q_pop = !q_empty && (!out_valid || out_ready);

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_value <= pix_c;
      run_length  <= q_seg.len;
      first_row   <= q_seg.row;
      first_col   <= q_seg.col;
      dest_index  <= dest;
      glyph_done  <= q_seg.done;
    end
  end

endmodule

// File: rtl/core/glyph_rle_decoder.sv
// A pixel byte's segment passes through the queue and then the output register before it is offered.
// Throughput: one byte per cycle while the queue has room; a repeat segment that wraps past two or more row
//   ends holds input while the row divider runs a bit per cycle.
// Input is held after reset and after each width or height write while glyph size and position are rebuilt.
// Reset (rst, synchronous): config to 8x8, clamp 255, RLE on; position and runs cleared.
module glyph_rle_decoder import grd_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            stream_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_value,
  output logic [7:0]            run_length,
  output logic [7:0]            first_row,
  output logic [7:0]            first_col,
  output logic [15:0]           dest_index,
  output logic                  glyph_done
);

  logic [CFG_DIM_W-1:0] glyph_width;
  logic [CFG_DIM_W-1:0] glyph_height;
  logic [7:0]           clamp_max;
  logic                 rle_enable;
  logic                 size_wr;
  logic                 push;
  seg_t                 push_seg;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  seg_t                 q_seg;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= RST_WIDTH;
      glyph_height <= RST_HEIGHT;
      clamp_max    <= RST_CLAMP;
      rle_enable   <= RST_RLE;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  glyph_width  <= CFG_DIM_W'(cfg_wdata);
        REG_HEIGHT: glyph_height <= CFG_DIM_W'(cfg_wdata);
        REG_CLAMP:  clamp_max    <= cfg_wdata[7:0];
        REG_RLE:    rle_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign size_wr = cfg_wr_en && ((cfg_reg_t'(cfg_index) == REG_WIDTH) ||
                                 (cfg_reg_t'(cfg_index) == REG_HEIGHT));

  grd_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk          (clk),
    .rst          (rst),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .rle_enable   (rle_enable),
    .size_wr      (size_wr),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stream_byte  (stream_byte),
    .push         (push),
    .push_seg     (push_seg),
    .q_full       (q_full)
  );

  grd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_seg (push_seg),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_seg  (q_seg)
  );

  grd_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk          (clk),
    .rst          (rst),
    .glyph_height (glyph_height),
    .clamp_max    (clamp_max),
    .q_empty      (q_empty),
    .q_seg        (q_seg),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .run_length   (run_length),
    .first_row    (first_row),
    .first_col    (first_col),
    .dest_index   (dest_index),
    .glyph_done   (glyph_done)
  );

endmodule

// File: bench/glyph_rle_decoder_test.sv
// Self-checking bench for the glyph run-length decoder: directed and random byte streams.
`timescale 1ns / 1ps

module glyph_rle_decoder_test;
  import grd_pkg::*;

  // One run segment as the decoder should report it
  typedef struct packed {
    logic [7:0]  pix;
    logic [7:0]  len;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] dest;
    logic        done;
  } segment_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            stream_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            pixel_value;
  logic [7:0]            run_length;
  logic [7:0]            first_row;
  logic [7:0]            first_col;
  logic [15:0]           dest_index;
  logic                  glyph_done;

  // Stream bytes not yet accepted; the head is the one on offer
  logic [7:0]  pending_bytes[$];
  // Segments the decoder still owes, oldest first
  segment_t    segments_due[$];
  segment_t    seg_want;
  bit          req_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // Mirror of the decoder's registers and run state
  logic [CFG_DIM_W-1:0] glyph_w;
  logic [CFG_DIM_W-1:0] glyph_h;
  logic [7:0]           clamp_limit;
  logic                 rle_on;
  logic [7:0]           lit_left;
  logic                 want_colour;
  logic [7:0]           repeat_len;
  logic [7:0]           next_row;
  logic [7:0]           next_col;

  glyph_rle_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .run_length  (run_length),
    .first_row   (first_row),
    .first_col   (first_col),
    .dest_index  (dest_index),
    .glyph_done  (glyph_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound a side to 1..256: zero counts as one, anything larger as 256
  function automatic int unsigned glyph_side(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > 9'd256) return 256;
    return v;
  endfunction

  // Drop run state and return to the top-left pixel
  function automatic void restart_glyph();
    lit_left    = '0;
    want_colour = 1'b0;
    repeat_len  = '0;
    next_row    = '0;
    next_col    = '0;
  endfunction

  // Queue a segment at the current position, cut at the glyph end, and advance
  function automatic void emit_segment(input logic [7:0] val, input int unsigned req_len);
    int unsigned w;
    int unsigned h;
    int unsigned pos;
    int unsigned left;
    int unsigned len;
    segment_t    s;
    w = glyph_side(glyph_w);
    h = glyph_side(glyph_h);
    // Restart when a size change left the position outside the glyph
    if (next_row >= h || next_col >= w) begin
      next_row = '0;
      next_col = '0;
    end
    pos  = next_row * w + next_col;
    left = w * h - pos;
    len  = (req_len > left) ? left : req_len;
    s.pix  = val;
    s.len  = 8'(len);
    s.row  = next_row;
    s.col  = next_col;
    s.dest = 16'(next_col * h + next_row);
    s.done = (len == left);
    segments_due.push_back(s);
    if (s.done) begin
      restart_glyph();
    end else begin
      pos += len;
      next_row = 8'(pos / w);
      next_col = 8'(pos % w);
    end
  endfunction

  // Apply one accepted stream byte to the mirrored decoder
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0] v;
    logic [7:0] len;
    v = (b > clamp_limit) ? clamp_limit : b;
    if (!rle_on) begin
      emit_segment(v, 1);
    end else if (lit_left != '0) begin
      lit_left = lit_left - 8'd1;
      emit_segment(v, 1);
    end else if (want_colour) begin
      len = repeat_len;
      want_colour = 1'b0;
      repeat_len  = '0;
      emit_segment(v, len);
    end else if (b < CODE_NOP) begin
      lit_left = b + 8'd1;
    end else if (b != CODE_NOP) begin
      want_colour = 1'b1;
      repeat_len  = 8'(REPEAT_OFFSET - {1'b0, b});
    end
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Offer requests on the falling edge; roll the stall dice each cycle and the idle dice when a new byte may be offered
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || req_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          stream_byte <= pending_bytes[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Sample both channels and the register port on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      req_taken   <= 1'b0;
      glyph_w     = RST_WIDTH;
      glyph_h     = RST_HEIGHT;
      clamp_limit = RST_CLAMP;
      rle_on      = RST_RLE;
      restart_glyph();
      segments_due.delete();
    end else begin
      req_taken <= in_valid && in_ready;
      // Check a delivered segment against the oldest one owed
      if (out_valid && out_ready) begin
        if (segments_due.size() == 0) begin
          report_mismatch("segment with none owed, pixel_value", pixel_value, 0);
        end else begin
          seg_want = segments_due.pop_front();
          if (pixel_value !== seg_want.pix)
            report_mismatch("pixel_value", pixel_value, seg_want.pix);
          if (run_length !== seg_want.len)
            report_mismatch("run_length", run_length, seg_want.len);
          if (first_row !== seg_want.row)
            report_mismatch("first_row", first_row, seg_want.row);
          if (first_col !== seg_want.col)
            report_mismatch("first_col", first_col, seg_want.col);
          if (dest_index !== seg_want.dest)
            report_mismatch("dest_index", dest_index, seg_want.dest);
          if (glyph_done !== seg_want.done)
            report_mismatch("glyph_done", glyph_done, seg_want.done);
        end
      end
      // Advance the mirror on each accepted request
      if (in_valid && in_ready) begin
        decode_byte(stream_byte);
        void'(pending_bytes.pop_front());
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WIDTH:  glyph_w     = cfg_wdata;
          REG_HEIGHT: glyph_h     = cfg_wdata;
          REG_CLAMP:  clamp_limit = cfg_wdata[7:0];
          REG_RLE:    rle_on      = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold until every byte is taken and every segment delivered, then let the pipe settle
  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || segments_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Queue about count bytes: mostly well-formed runs, some stray codes and noise
  task automatic queue_stream(input int unsigned count, input bit coded);
    int unsigned made;
    int unsigned n;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (!coded || pick < 8) begin
        pending_bytes.push_back(8'($urandom));
        made++;
      end else if (pick < 12) begin
        pending_bytes.push_back(CODE_NOP);
      end else if (pick < 55) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 127) : $urandom_range(0, 7);
        pending_bytes.push_back(8'(n));
        repeat (n + 1) pending_bytes.push_back(8'($urandom));
        made += n + 2;
      end else begin
        pending_bytes.push_back(8'($urandom_range(129, 255)));
        pending_bytes.push_back(8'($urandom));
        made += 2;
      end
    end
  endtask

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned idle_send[4];
    int unsigned idle_recv[4];
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    idle_send = '{0, 53, 0, 20};
    idle_recv = '{0, 0, 53, 20};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setup: one-pixel literal of 255, a no-op code, a short repeat,
    // then a longest repeat that runs past the glyph end
    pending_bytes.push_back(8'h00); pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(CODE_NOP);
    pending_bytes.push_back(8'hFF); pending_bytes.push_back(8'h05);
    pending_bytes.push_back(8'h81); pending_bytes.push_back(8'h00);
    // Longest literal, with pixel bytes that look like codes; leave it open
    pending_bytes.push_back(8'h7F); pending_bytes.push_back(8'h01);
    pending_bytes.push_back(CODE_NOP); pending_bytes.push_back(8'hFE);
    wait_for_drain();
    // Clamp pixels mid-literal
    write_reg(REG_CLAMP, 9'h010);
    pending_bytes.push_back(8'h55); pending_bytes.push_back(8'h00);
    wait_for_drain();
    // Raw bytes while the literal count is still pending
    write_reg(REG_RLE, 9'd0);
    pending_bytes.push_back(8'hFF); pending_bytes.push_back(CODE_NOP);
    wait_for_drain();
    // Shrink the glyph under the current position; run to its end
    write_reg(REG_WIDTH, 9'd2);
    write_reg(REG_HEIGHT, 9'd2);
    pending_bytes.push_back(8'h01); pending_bytes.push_back(8'h02);
    pending_bytes.push_back(8'h03); pending_bytes.push_back(8'h04);
    wait_for_drain();
    // Out-of-range sides: zero width, oversize height, then the reverse
    write_reg(REG_RLE, 9'd1);
    write_reg(REG_CLAMP, 9'd255);
    write_reg(REG_WIDTH, 9'd0);
    write_reg(REG_HEIGHT, 9'd511);
    pending_bytes.push_back(8'hFE); pending_bytes.push_back(8'h07);
    wait_for_drain();
    write_reg(REG_WIDTH, 9'd300);
    write_reg(REG_HEIGHT, 9'd0);
    pending_bytes.push_back(8'h81); pending_bytes.push_back(8'hAA);
    wait_for_drain();

    // Random phases over sizes, clamps, modes and idle patterns
    for (int p = 0; p < 10; p++) begin
      send_idle_pct  = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      case (p)
        4: begin
          w = 9'd256;
          h = 9'd256;
        end
        8: begin
          w = 9'd0;
          h = 9'($urandom_range(257, 511));
        end
        default: begin
          w = 9'($urandom_range(1, 16));
          h = 9'($urandom_range(1, 16));
        end
      endcase
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_CLAMP, (p == 1) ? 9'd0 : (p == 2) ? 9'd255 : 9'($urandom_range(0, 255)));
      write_reg(REG_RLE, (p == 3 || p == 7) ? 9'd0 : 9'd1);
      if (p == 5) begin
        // Hold the sender until every owed segment is out, then resume
        queue_stream(25, 1'b1);
        wait_for_drain();
        queue_stream(25, 1'b1);
      end else begin
        queue_stream(50, !(p == 3 || p == 7));
      end
      wait_for_drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
